/* hdl/aec_pkg.sv */
// Shared types, constants and helper functions of the alarm escalation controller.
`default_nettype none
package aec_pkg;

	localparam int CACHE_DEPTH = 8;
	localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
	localparam int POS_W = CNT_W + 1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 16;

	localparam logic [15:0] PRE_ALARM_TICKS_RST = 16'd15000;
	localparam logic [15:0] ACKED_TICKS_RST = 16'd2000;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

	localparam logic [3:0] FALL_TYPE = 4'd7;
	localparam logic [3:0] TYPE_MANUAL = 4'd8;
	localparam logic [3:0] TYPE_CALL_FAMILY = 4'd9;
	localparam logic [3:0] LINK_FALL = 4'd6;
	localparam logic [3:0] LINK_MANUAL = 4'd7;
	localparam logic [3:0] LINK_CALL_FAMILY = 4'd9;
	localparam logic [3:0] LINK_NONE = 4'd0;

	typedef enum logic [1:0] {
		CFG_PRE_ALARM = 2'd0,
		CFG_ACKED = 2'd1,
		CFG_RETRY = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		MODE_TRIGGER = 3'd0,
		MODE_CANCEL = 3'd1,
		MODE_ACK = 3'd2,
		MODE_TICK = 3'd3,
		MODE_RESEND = 3'd4,
		MODE_FIND = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		AL_IDLE = 2'd0,
		AL_PRE = 2'd1,
		AL_ALARM = 2'd2,
		AL_ACKED = 2'd3
	} alarm_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_EXEC,
		CTL_WALK
	} ctl_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SIMPLE,
		OP_ADVANCE,
		OP_ACK_DONE,
		OP_FIND_HIT,
		OP_EMPTY,
		OP_RESEND
	} op_t;

	typedef struct packed {
		op_t op;
		logic ack_mark;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic walk_end;
		logic match;
		logic elig;
		logic more;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] trig_type;
		logic [15:0] alert_value;
		logic [31:0] time_stamp;
		logic [31:0] lookup_id;
	} ev_item_t;

	typedef struct packed {
		logic [1:0] alarm_state;
		logic record_valid;
		logic [31:0] record_id;
		logic [3:0] record_type;
		logic [15:0] record_value;
		logic [31:0] record_time;
		logic [3:0] record_retries;
		logic record_acked;
		logic last_result;
	} rec_item_t;

	function automatic logic [3:0] map_type(input logic [3:0] t);
		logic [3:0] r;
		if (t >= 4'd1 && t <= 4'd5) r = t;
		else if (t == FALL_TYPE) r = LINK_FALL;
		else if (t == TYPE_MANUAL) r = LINK_MANUAL;
		else if (t == TYPE_CALL_FAMILY) r = LINK_CALL_FAMILY;
		else r = LINK_NONE;
		return r;
	endfunction

	// Ring slot at an offset from the head, wrapped once.
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [POS_W-1:0] s;
		s = POS_W'(head) + POS_W'(off);
		if (s >= POS_W'(CACHE_DEPTH)) s = s - POS_W'(CACHE_DEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/aec_event_if.sv */
// Input channel of alarm events: valid, ready and the event fields.
`default_nettype none
interface aec_event_if;
	logic valid;
	logic ready;
	logic [2:0] mode;
	logic [3:0] trig_type;
	logic [15:0] alert_value;
	logic [31:0] time_stamp;
	logic [31:0] lookup_id;

	modport source (output valid, output mode, output trig_type, output alert_value,
		output time_stamp, output lookup_id, input ready);
	modport sink (input valid, input mode, input trig_type, input alert_value,
		input time_stamp, input lookup_id, output ready);
endinterface
`default_nettype wire

/* hdl/aec_record_if.sv */
// Output channel of alarm results: valid, ready and the result fields.
`default_nettype none
interface aec_record_if;
	logic valid;
	logic ready;
	logic [1:0] alarm_state;
	logic record_valid;
	logic [31:0] record_id;
	logic [3:0] record_type;
	logic [15:0] record_value;
	logic [31:0] record_time;
	logic [3:0] record_retries;
	logic record_acked;
	logic last_result;

	modport source (output valid, output alarm_state, output record_valid, output record_id,
		output record_type, output record_value, output record_time, output record_retries,
		output record_acked, output last_result, input ready);
	modport sink (input valid, input alarm_state, input record_valid, input record_id,
		input record_type, input record_value, input record_time, input record_retries,
		input record_acked, input last_result, output ready);
endinterface
`default_nettype wire

/* hdl/aec_controller.sv */
// Sequencing state machine: capture, execute, and the cache walk for ack, find and resend.
`default_nettype none
module aec_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ev_valid,
	output logic             ev_ready,
	input  aec_pkg::status_t status,
	output aec_pkg::cmd_t    cmd
);
	import aec_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CTL_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ev_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.ack_mark = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				ev_ready = 1'b1;
				if (ev_valid) begin
					cmd.op = OP_LOAD;
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				if (status.mode == MODE_ACK || status.mode == MODE_FIND ||
						status.mode == MODE_RESEND) begin
					state_d = CTL_WALK;
				end else if (status.out_free) begin
					cmd.op = OP_SIMPLE;
					state_d = CTL_IDLE;
				end
			end
			CTL_WALK: begin
				if (status.walk_end) begin
					if (status.out_free) begin
						cmd.op = (status.mode == MODE_ACK) ? OP_ACK_DONE : OP_EMPTY;
						state_d = CTL_IDLE;
					end
				end else if (status.mode == MODE_RESEND) begin
					if (!status.elig) cmd.op = OP_ADVANCE;
					else if (status.out_free) begin
						cmd.op = OP_RESEND;
						if (!status.more) state_d = CTL_IDLE;
					end
				end else if (!status.match) begin
					cmd.op = OP_ADVANCE;
				end else if (status.out_free) begin
					// first hit is the oldest matching entry
					if (status.mode == MODE_ACK) begin
						cmd.op = OP_ACK_DONE;
						cmd.ack_mark = 1'b1;
					end else begin
						cmd.op = OP_FIND_HIT;
					end
					state_d = CTL_IDLE;
				end
			end
			default: state_d = CTL_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/aec_datapath.sv */
// Alarm state, configuration, ring cache of records, cache walk pointer and result register.
`default_nettype none
module aec_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  aec_pkg::cmd_t                      cmd,
	output aec_pkg::status_t                   status,
	input  aec_pkg::ev_item_t                  ev,
	input  logic                               cfg_wen,
	input  logic [aec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aec_pkg::CFG_W-1:0]          cfg_data,
	output aec_pkg::rec_item_t                 rec,
	output logic                               rec_valid,
	input  logic                               rec_ready
);
	import aec_pkg::*;

	logic [15:0] pre_ticks_q, acked_ticks_q;
	logic [3:0] retry_q;

	ev_item_t in_q;
	alarm_t alarm_q;
	logic [15:0] timeout_q;
	logic [3:0] cur_type_q;
	logic [15:0] cur_value_q;
	logic [31:0] event_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] walk_q;

	logic [31:0] e_id [CACHE_DEPTH];
	logic [3:0] e_type [CACHE_DEPTH];
	logic [15:0] e_value [CACHE_DEPTH];
	logic [31:0] e_time [CACHE_DEPTH];
	logic [3:0] e_retries [CACHE_DEPTH];
	logic e_acked [CACHE_DEPTH];

	rec_item_t out_q, out_d;
	logic out_valid_q;
	logic out_free;
	logic emit;

	alarm_t nst, ack_st;
	logic [15:0] nto, ack_to;
	logic send;
	logic [3:0] ctype;
	logic [15:0] cval;
	logic [31:0] ev_next;
	logic [3:0] link_type;
	logic full;
	logic [IDX_W-1:0] send_slot, cur_slot;
	logic more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_ticks_q <= PRE_ALARM_TICKS_RST;
			acked_ticks_q <= ACKED_TICKS_RST;
			retry_q <= RETRY_LIMIT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PRE_ALARM: pre_ticks_q <= cfg_data;
				CFG_ACKED: acked_ticks_q <= cfg_data;
				CFG_RETRY: retry_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) in_q <= ev;
	end

	assign cur_slot = slot_add(head_q, walk_q);
	assign full = (count_q == CNT_W'(CACHE_DEPTH));
	assign send_slot = full ? head_q : slot_add(head_q, count_q);
	assign ev_next = event_q + 32'd1;
	assign link_type = map_type(ctype);

	// modes without a cache walk: trigger, cancel, tick and the unknown codes
	always_comb begin
		nst = alarm_q;
		nto = timeout_q;
		send = 1'b0;
		ctype = cur_type_q;
		cval = cur_value_q;
		unique case (mode_t'(in_q.mode))
			MODE_TRIGGER: begin
				ctype = in_q.trig_type;
				cval = in_q.alert_value;
				if (in_q.trig_type == FALL_TYPE && alarm_q == AL_IDLE) begin
					nst = AL_PRE;
					nto = pre_ticks_q;
				end else if (!(in_q.trig_type == FALL_TYPE && alarm_q == AL_PRE)) begin
					nst = AL_ALARM;
					nto = 16'd0;
					send = 1'b1;
				end
			end
			MODE_CANCEL: begin
				if (alarm_q == AL_PRE || alarm_q == AL_ALARM) begin
					nst = AL_IDLE;
					nto = 16'd0;
				end
			end
			MODE_TICK: begin
				if (alarm_q == AL_PRE || alarm_q == AL_ACKED) begin
					if (timeout_q <= 16'd1) begin
						nto = 16'd0;
						if (alarm_q == AL_PRE) begin
							nst = AL_ALARM;
							send = 1'b1;
						end else begin
							nst = AL_IDLE;
						end
					end else begin
						nto = timeout_q - 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		ack_st = alarm_q;
		ack_to = timeout_q;
		if (alarm_q == AL_ALARM) begin
			ack_st = AL_ACKED;
			ack_to = acked_ticks_q;
		end
	end

	// any eligible entry later in the ring than the walk position
	always_comb begin
		logic [POS_W-1:0] pos_v;
		more = 1'b0;
		for (int s = 0; s < CACHE_DEPTH; s++) begin
			if (IDX_W'(s) >= head_q) pos_v = POS_W'(s) - POS_W'(head_q);
			else pos_v = POS_W'(s) + POS_W'(CACHE_DEPTH) - POS_W'(head_q);
			if (pos_v < POS_W'(count_q) && pos_v > POS_W'(walk_q) && !e_acked[s] &&
					e_retries[s] < retry_q) more = 1'b1;
		end
	end

	assign out_free = !out_valid_q || rec_ready;

	assign status.mode = in_q.mode;
	assign status.walk_end = (walk_q == count_q);
	assign status.match = (e_id[cur_slot] == in_q.lookup_id);
	assign status.elig = !e_acked[cur_slot] && (e_retries[cur_slot] < retry_q);
	assign status.more = more;
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= AL_IDLE;
			timeout_q <= 16'd0;
			cur_type_q <= 4'd0;
			cur_value_q <= 16'd0;
			event_q <= 32'd0;
			head_q <= '0;
			count_q <= '0;
			walk_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: walk_q <= '0;
				OP_ADVANCE, OP_RESEND: walk_q <= walk_q + 1'b1;
				OP_SIMPLE: begin
					alarm_q <= nst;
					timeout_q <= nto;
					cur_type_q <= ctype;
					cur_value_q <= cval;
					if (send) begin
						event_q <= ev_next;
						if (full) head_q <= slot_add(head_q, CNT_W'(1));
						else count_q <= count_q + 1'b1;
					end
				end
				OP_ACK_DONE: begin
					alarm_q <= ack_st;
					timeout_q <= ack_to;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SIMPLE && send) begin
			e_id[send_slot] <= ev_next;
			e_type[send_slot] <= link_type;
			e_value[send_slot] <= cval;
			e_time[send_slot] <= in_q.time_stamp;
			e_retries[send_slot] <= 4'd0;
			e_acked[send_slot] <= 1'b0;
		end else if (cmd.op == OP_ACK_DONE && cmd.ack_mark) begin
			e_acked[cur_slot] <= 1'b1;
		end else if (cmd.op == OP_RESEND) begin
			e_retries[cur_slot] <= e_retries[cur_slot] + 4'd1;
		end
	end

	assign emit = (cmd.op == OP_SIMPLE) || (cmd.op == OP_ACK_DONE) ||
		(cmd.op == OP_FIND_HIT) || (cmd.op == OP_EMPTY) || (cmd.op == OP_RESEND);

	always_comb begin
		out_d = '0;
		out_d.alarm_state = alarm_q;
		out_d.last_result = 1'b1;
		unique case (cmd.op)
			OP_SIMPLE: begin
				out_d.alarm_state = nst;
				if (send) begin
					out_d.record_valid = 1'b1;
					out_d.record_id = ev_next;
					out_d.record_type = link_type;
					out_d.record_value = cval;
					out_d.record_time = in_q.time_stamp;
				end
			end
			OP_ACK_DONE: out_d.alarm_state = ack_st;
			OP_FIND_HIT, OP_RESEND: begin
				out_d.record_valid = 1'b1;
				out_d.record_id = e_id[cur_slot];
				out_d.record_type = e_type[cur_slot];
				out_d.record_value = e_value[cur_slot];
				out_d.record_time = e_time[cur_slot];
				out_d.record_retries = e_retries[cur_slot];
				if (cmd.op == OP_FIND_HIT) out_d.record_acked = e_acked[cur_slot];
				else out_d.last_result = !more;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (rec_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= out_d;
	end

	assign rec = out_q;
	assign rec_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free) else $error("result loaded over an untaken result");
	a_ring_grows_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1))
		else $error("ring fill jumped");
	a_alarm_no_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(alarm_q == AL_ALARM) |-> (timeout_q == 16'd0)) else $error("countdown live in alarming");
`endif

endmodule
`default_nettype wire

/* hdl/alarm_escalation_controller_top.sv */
// Top level of the alarm escalation controller: channels, configuration port and the two halves.
`default_nettype none
// Alarm escalation controller. Each event transaction (trigger, cancel, ack, one-ms tick,
// resend or find) moves the four-state alarm machine (idle, pre-alarm, alarming,
// acknowledged) and yields one or more result transactions, the final one flagged by
// last_result. Every entry to alarming and every trigger while alarming sends a record
// with a fresh event id into an eight-entry ring cache that drops its oldest entry when
// full. Trigger, cancel, tick and unknown modes pass through capture, then execute.
// Ack, find and resend walk the cache one entry per cycle, holding at a hit until the
// output register is free; a resend emits a record for each eligible entry it visits.
// A result waiting in the output register does not block acceptance of the next event,
// but a new result is loaded only once the previous one has been taken, so backpressure
// stretches the step.
// Configuration writes are registered and are meant for idle periods only.
module alarm_escalation_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	aec_event_if.sink                      events,
	aec_record_if.source                   records,
	input  logic                           cfg_wen,
	input  logic [aec_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aec_pkg::CFG_W-1:0]      cfg_data
);
	import aec_pkg::*;

	cmd_t cmd;
	status_t status;
	ev_item_t ev;
	rec_item_t rec;
	logic rec_valid;

	// pack the event fields for capture in the datapath
	assign ev.mode = events.mode;
	assign ev.trig_type = events.trig_type;
	assign ev.alert_value = events.alert_value;
	assign ev.time_stamp = events.time_stamp;
	assign ev.lookup_id = events.lookup_id;

	aec_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (events.valid),
		.ev_ready (events.ready),
		.status   (status),
		.cmd      (cmd)
	);

	aec_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.ev        (ev),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_ready (records.ready)
	);

	// drive the result channel straight from the output register
	assign records.valid = rec_valid;
	assign records.alarm_state = rec.alarm_state;
	assign records.record_valid = rec.record_valid;
	assign records.record_id = rec.record_id;
	assign records.record_type = rec.record_type;
	assign records.record_value = rec.record_value;
	assign records.record_time = rec.record_time;
	assign records.record_retries = rec.record_retries;
	assign records.record_acked = rec.record_acked;
	assign records.last_result = rec.last_result;

endmodule
`default_nettype wire
